// ----- hdl/pnd_pkg.sv -----
package pnd_pkg;

   localparam int MAX_NAME_LEN = 16;
   localparam int CNT_W = $clog2(MAX_NAME_LEN + 1);
   localparam int IDX_W = $clog2(MAX_NAME_LEN);

   // Kind codes stored in the pad queue.
   localparam logic [1:0] PAD_SPACE       = 2'd0;
   localparam logic [1:0] PAD_SHIFT_SPACE = 2'd1;
   localparam logic [1:0] PAD_NUL         = 2'd2;

   localparam logic [7:0] BYTE_SPACE       = 8'h20;
   localparam logic [7:0] BYTE_SHIFT_SPACE = 8'hA0;
   localparam logic [7:0] BYTE_NUL         = 8'h00;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DASH       = 8'h2D;
   localparam logic [7:0] CHAR_BAR        = 8'h7C;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PAD,
      ST_BYTE,
      ST_END
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_PAD,
      EMIT_BYTE,
      EMIT_END
   } emit_type;

   typedef struct packed {
      logic     take;
      logic     next_pad;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic room;
      logic is_pad;
      logic last;
      logic pending_any;
      logic drain_more;
      logic out_free;
   } status_type;

   function automatic logic [7:0] pad_byte(logic [1:0] kind);
      logic [7:0] b;
      case (kind)
         PAD_SPACE:       b = BYTE_SPACE;
         PAD_SHIFT_SPACE: b = BYTE_SHIFT_SPACE;
         default:         b = BYTE_NUL;
      endcase
      return b;
   endfunction

   function automatic logic [1:0] pad_kind(logic [7:0] b);
      logic [1:0] kind;
      if (b == BYTE_SPACE) begin
         kind = PAD_SPACE;
      end else if (b == BYTE_SHIFT_SPACE) begin
         kind = PAD_SHIFT_SPACE;
      end else begin
         kind = PAD_NUL;
      end
      return kind;
   endfunction

   function automatic logic [7:0] display_char(logic [7:0] b);
      logic [7:0] c;
      logic [7:0] r;
      c = b;
      // Fold the shifted letter and graphics ranges onto their base codes.
      if (c >= 8'hC0 && c <= 8'hDF) begin
         c = c - 8'h60;
      end else if (c >= 8'hE0) begin
         c = c - 8'h40;
      end
      if (c >= 8'h20 && c <= 8'h5A) begin
         r = c;
      end else if (c == 8'h5B || c == 8'h5D) begin
         r = c;
      end else if (c < 8'h20 || (c >= 8'h80 && c <= 8'h9F)) begin
         r = CHAR_UNDERSCORE;
      end else if (c == BYTE_SHIFT_SPACE) begin
         r = BYTE_SPACE;
      end else if (c >= 8'hA1 && c <= 8'hBF) begin
         r = CHAR_HASH;
      end else begin
         case (c)
            8'h60, 8'h63, 8'h64, 8'h77, 8'h78: r = CHAR_DASH;
            8'h5C, 8'h62, 8'h65, 8'h67, 8'h74: r = CHAR_BAR;
            8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6E, 8'h6F, 8'h70,
            8'h72, 8'h73, 8'h75, 8'h7A, 8'h7B, 8'h7D: r = CHAR_PLUS;
            8'h61, 8'h66, 8'h76, 8'h79, 8'h7C, 8'h7E, 8'h7F: r = CHAR_HASH;
            default: r = CHAR_DOT;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- hdl/petscii_name_display_converter_core.sv -----
// Channel   Direction  Handshake          Word
// req_      in         req_valid/stall    name_byte, last_byte
// rsp_      out        rsp_valid/stall    out_char, has_char, name_end
// csr_      in         csr_valid/ready    raw_mode
//
// A pad byte, or a byte dropped past the length limit, is taken in idle and leaves
// the FSM in idle unless it is the last byte. A kept non-pad byte first drains the
// held pads, each with a queue read step and an output step, and is then emitted.
// A name that ends with nothing to emit goes to ST_END for the end word.
// Reset clears the mode register, the queue count, the byte count and the FSM.
// A stall on rsp_ holds the FSM in its emitting state; req_ is taken only in idle.
module petscii_name_display_converter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_name_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_name_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_raw_mode
);

   pnd_pkg::cmd_type    cmd;
   pnd_pkg::status_type status;

   pnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   pnd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_name_byte (req_name_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_raw_mode  (csr_raw_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_has_char  (rsp_has_char),
      .rsp_name_end  (rsp_name_end)
   );

endmodule

// ----- hdl/pnd_ctrl.sv -----
module pnd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  pnd_pkg::status_type status,
   output logic                req_stall,
   output pnd_pkg::cmd_type    cmd
);

   pnd_pkg::state_type state_ff;
   pnd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pnd_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.room && !status.is_pad) begin
                  state_in = status.pending_any ? pnd_pkg::ST_FETCH : pnd_pkg::ST_BYTE;
               end else if (status.last) begin
                  state_in = pnd_pkg::ST_END;
               end
            end
         end
         pnd_pkg::ST_FETCH: state_in = pnd_pkg::ST_PAD;
         pnd_pkg::ST_PAD: begin
            if (status.out_free) begin
               state_in = status.drain_more ? pnd_pkg::ST_FETCH : pnd_pkg::ST_BYTE;
            end
         end
         pnd_pkg::ST_BYTE: begin
            if (status.out_free) begin
               state_in = pnd_pkg::ST_IDLE;
            end
         end
         pnd_pkg::ST_END: begin
            if (status.out_free) begin
               state_in = pnd_pkg::ST_IDLE;
            end
         end
         default: state_in = pnd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.take     = 1'b0;
      cmd.next_pad = 1'b0;
      cmd.emit     = pnd_pkg::EMIT_NONE;
      case (state_ff)
         pnd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.take  = req_valid;
         end
         pnd_pkg::ST_FETCH: begin
         end
         pnd_pkg::ST_PAD: begin
            if (status.out_free) begin
               cmd.emit     = pnd_pkg::EMIT_PAD;
               cmd.next_pad = 1'b1;
            end
         end
         pnd_pkg::ST_BYTE: begin
            if (status.out_free) begin
               cmd.emit = pnd_pkg::EMIT_BYTE;
            end
         end
         pnd_pkg::ST_END: begin
            if (status.out_free) begin
               cmd.emit = pnd_pkg::EMIT_END;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/pnd_datapath.sv -----
module pnd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pnd_pkg::cmd_type    cmd,
   output pnd_pkg::status_type status,
   input  logic [7:0]          req_name_byte,
   input  logic                req_last_byte,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_raw_mode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_has_char,
   output logic                rsp_name_end
);

   localparam logic [pnd_pkg::CNT_W-1:0] MAX_CNT = pnd_pkg::CNT_W'(pnd_pkg::MAX_NAME_LEN);
   localparam logic [pnd_pkg::CNT_W-1:0] ONE_CNT = pnd_pkg::CNT_W'(1);

   logic [1:0] pad_mem [pnd_pkg::MAX_NAME_LEN];

   logic                      raw_mode_ff;
   logic [pnd_pkg::CNT_W-1:0] pending_ff;
   logic [pnd_pkg::CNT_W-1:0] pending_in;
   logic [pnd_pkg::CNT_W-1:0] taken_ff;
   logic [pnd_pkg::CNT_W-1:0] taken_in;
   logic [pnd_pkg::CNT_W-1:0] drain_idx_ff;
   logic [pnd_pkg::CNT_W-1:0] drain_idx_in;
   logic [pnd_pkg::CNT_W-1:0] drain_idx_next;
   logic [1:0]                rd_kind_ff;
   logic [7:0]                byte_ff;
   logic                      last_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [7:0]                out_char_ff;
   logic [7:0]                out_char_in;
   logic                      has_char_ff;
   logic                      has_char_in;
   logic                      name_end_ff;
   logic                      name_end_in;

   logic                      req_is_pad;
   logic                      room;
   logic                      queue_write;
   logic [7:0]                emit_byte;
   logic [7:0]                emit_conv;

   assign csr_ready = 1'b1;

   assign req_is_pad = (req_name_byte == pnd_pkg::BYTE_SPACE) ||
                       (req_name_byte == pnd_pkg::BYTE_SHIFT_SPACE) ||
                       (req_name_byte == pnd_pkg::BYTE_NUL);
   assign room        = taken_ff < MAX_CNT;
   assign queue_write = cmd.take && room && req_is_pad && (pending_ff < MAX_CNT);
   assign drain_idx_next = drain_idx_ff + ONE_CNT;

   assign status.room        = room;
   assign status.is_pad      = req_is_pad;
   assign status.last        = req_last_byte;
   assign status.pending_any = pending_ff != '0;
   assign status.drain_more  = drain_idx_next < pending_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (queue_write) begin
         pad_mem[pending_ff[pnd_pkg::IDX_W-1:0]] <= pnd_pkg::pad_kind(req_name_byte);
      end
      rd_kind_ff <= pad_mem[drain_idx_ff[pnd_pkg::IDX_W-1:0]];
   end

   always_comb begin
      taken_in     = taken_ff;
      pending_in   = pending_ff;
      drain_idx_in = drain_idx_ff;
      if (cmd.take) begin
         drain_idx_in = '0;
         if (req_last_byte) begin
            taken_in = '0;
         end else if (room) begin
            taken_in = taken_ff + ONE_CNT;
         end
         // A name that ends without a kept byte drops its held pads.
         if (req_last_byte && !(room && !req_is_pad)) begin
            pending_in = '0;
         end else if (queue_write) begin
            pending_in = pending_ff + ONE_CNT;
         end
      end
      if (cmd.next_pad) begin
         drain_idx_in = drain_idx_next;
      end
      if (cmd.emit == pnd_pkg::EMIT_BYTE) begin
         pending_in = '0;
      end
   end

   always_comb begin
      case (cmd.emit)
         pnd_pkg::EMIT_PAD: emit_byte = pnd_pkg::pad_byte(rd_kind_ff);
         default:           emit_byte = byte_ff;
      endcase
      emit_conv = raw_mode_ff ? emit_byte : pnd_pkg::display_char(emit_byte);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      has_char_in  = has_char_ff;
      name_end_in  = name_end_ff;
      case (cmd.emit)
         pnd_pkg::EMIT_PAD: begin
            rsp_valid_in = 1'b1;
            out_char_in  = emit_conv;
            has_char_in  = 1'b1;
            name_end_in  = 1'b0;
         end
         pnd_pkg::EMIT_BYTE: begin
            rsp_valid_in = 1'b1;
            out_char_in  = emit_conv;
            has_char_in  = 1'b1;
            name_end_in  = last_ff;
         end
         pnd_pkg::EMIT_END: begin
            rsp_valid_in = 1'b1;
            out_char_in  = '0;
            has_char_in  = 1'b0;
            name_end_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff  <= 1'b0;
         pending_ff   <= '0;
         taken_ff     <= '0;
         drain_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            raw_mode_ff <= csr_raw_mode;
         end
         pending_ff   <= pending_in;
         taken_ff     <= taken_in;
         drain_idx_ff <= drain_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         byte_ff <= req_name_byte;
         last_ff <= req_last_byte;
      end
      out_char_ff <= out_char_in;
      has_char_ff <= has_char_in;
      name_end_ff <= name_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_has_char = has_char_ff;
   assign rsp_name_end = name_end_ff;

endmodule

// ----- verif/petscii_name_display_converter_core_tb.sv -----
module petscii_name_display_converter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } name_word_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       has;
      logic       fin;
   } char_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_name_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_name_end;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_raw_mode = 1'b0;

   name_word_type name_bytes_q[$];
   char_word_type expected_chars[$];

   // Shadow of the converter state.
   logic       raw_now = 1'b0;
   logic [7:0] held_pads[$];
   int         bytes_seen = 0;

   logic quiet = 1'b0;
   int   errors = 0;
   int   items_taken = 0;
   int   chars_checked = 0;
   int   names_done = 0;
   int   mode_writes = 0;
   int   overlong_names = 0;
   int   cycle_count = 0;
   int   gap_left = 0;
   int   stall_left = 0;

   petscii_name_display_converter_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_name_byte(req_name_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_has_char (rsp_has_char),
      .rsp_name_end (rsp_name_end),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_raw_mode (csr_raw_mode)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic logic [7:0] petscii_to_ascii(logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (c >= 8'hE0) begin
         c = c - 8'h40;
      end else if (c >= 8'hC0) begin
         c = c - 8'h60;
      end
      if (c < 8'h20 || (c >= 8'h80 && c < 8'hA0)) return pnd_pkg::CHAR_UNDERSCORE;
      if (c <= 8'h5B || c == 8'h5D) return c;
      if (c == 8'hA0) return pnd_pkg::BYTE_SPACE;
      if (c > 8'hA0) return pnd_pkg::CHAR_HASH;
      // What is left is the graphics block from $5C to $7F.
      case (c)
         8'h60, 8'h63, 8'h64, 8'h77, 8'h78: return pnd_pkg::CHAR_DASH;
         8'h5C, 8'h62, 8'h65, 8'h67, 8'h74: return pnd_pkg::CHAR_BAR;
         8'h61, 8'h66, 8'h76, 8'h79, 8'h7C, 8'h7E, 8'h7F: return pnd_pkg::CHAR_HASH;
         8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6E, 8'h6F, 8'h70, 8'h72, 8'h73,
         8'h75, 8'h7A, 8'h7B, 8'h7D: return pnd_pkg::CHAR_PLUS;
         default: return pnd_pkg::CHAR_DOT;
      endcase
   endfunction

   function automatic logic [7:0] shown_char(logic [7:0] b);
      return raw_now ? b : petscii_to_ascii(b);
   endfunction

   task automatic expect_word(logic [7:0] ch, logic has, logic fin);
      char_word_type w;
      w.ch = ch;
      w.has = has;
      w.fin = fin;
      expected_chars = {expected_chars, w};
   endtask

   task automatic hold_pad(logic [7:0] b);
      held_pads = {held_pads, b};
   endtask

   task automatic predict_name_byte(logic [7:0] b, logic last);
      logic end_sent;
      end_sent = 1'b0;
      if (bytes_seen < pnd_pkg::MAX_NAME_LEN) begin
         bytes_seen++;
         if (b == pnd_pkg::BYTE_SPACE || b == pnd_pkg::BYTE_SHIFT_SPACE ||
             b == pnd_pkg::BYTE_NUL) begin
            if (held_pads.size() < pnd_pkg::MAX_NAME_LEN) hold_pad(b);
         end else begin
            foreach (held_pads[i]) expect_word(shown_char(held_pads[i]), 1'b1, 1'b0);
            held_pads.delete();
            expect_word(shown_char(b), 1'b1, last);
            end_sent = last;
         end
      end
      if (last) begin
         if (!end_sent) expect_word(8'h00, 1'b0, 1'b1);
         held_pads.delete();
         bytes_seen = 0;
      end
   endtask

   // Input driver.
   always @(posedge clock) begin
      name_word_type nxt;
      logic show;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         show = 1'b0;
         if (req_valid && !req_stall) begin
            predict_name_byte(req_name_byte, req_last_byte);
            items_taken++;
            gap_left = draw_wait();
            show = (gap_left == 0 && name_bytes_q.size() != 0);
         end else if (!req_valid) begin
            if (gap_left != 0) begin
               gap_left--;
            end else begin
               show = (name_bytes_q.size() != 0);
            end
         end
         if (show) begin
            nxt = name_bytes_q.pop_front();
            req_valid <= 1'b1;
            req_name_byte <= nxt.code;
            req_last_byte <= nxt.last;
         end else if (req_valid && !req_stall) begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      char_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got char %02h has %b end %b",
                        $time, rsp_out_char, rsp_has_char, rsp_name_end);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch) begin
                  errors++;
                  $display("%0t: out_char expected %02h, got %02h", $time, want.ch,
                           rsp_out_char);
               end
               if (rsp_has_char !== want.has) begin
                  errors++;
                  $display("%0t: has_char expected %b, got %b", $time, want.has,
                           rsp_has_char);
               end
               if (rsp_name_end !== want.fin) begin
                  errors++;
                  $display("%0t: name_end expected %b, got %b", $time, want.fin,
                           rsp_name_end);
               end
            end
            chars_checked++;
            if (rsp_name_end) names_done++;
            stall_left = draw_wait();
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
                  expected_chars.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic add_byte(logic [7:0] b, logic last);
      name_word_type w;
      w.code = b;
      w.last = last;
      name_bytes_q = {name_bytes_q, w};
   endtask

   function automatic logic [7:0] random_name_byte();
      case ($urandom_range(0, 9))
         0: return pnd_pkg::BYTE_SPACE;
         1: return pnd_pkg::BYTE_SHIFT_SPACE;
         2: return pnd_pkg::BYTE_NUL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_random_name(int len);
      for (int i = 0; i < len; i++) add_byte(random_name_byte(), i == len - 1);
   endtask

   task automatic add_random_phase(int target);
      int len;
      while (name_bytes_q.size() < target) begin
         if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(pnd_pkg::MAX_NAME_LEN + 1, pnd_pkg::MAX_NAME_LEN + 6);
            overlong_names++;
         end else begin
            len = $urandom_range(1, pnd_pkg::MAX_NAME_LEN);
         end
         add_random_name(len);
      end
      // Now and then leave a name open so that its held pads see a mode change.
      if ($urandom_range(0, 1) == 1) begin
         add_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
         add_byte(pnd_pkg::BYTE_SPACE, 1'b0);
         add_byte(pnd_pkg::BYTE_SHIFT_SPACE, 1'b0);
      end
   endtask

   // Sampled on the falling edge so that the driver's updates have settled.
   task automatic wait_drained();
      do @(negedge clock);
      while (name_bytes_q.size() != 0 || req_valid || expected_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_raw_mode <= v;
      do @(posedge clock);
      while (!csr_ready);
      raw_now = v;
      mode_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      @(negedge clock);
      add_byte(8'h41, 1'b1);
      add_byte(pnd_pkg::BYTE_SPACE, 1'b1);
      add_byte(8'h41, 1'b0);
      add_byte(pnd_pkg::BYTE_SPACE, 1'b0);
      add_byte(pnd_pkg::BYTE_SHIFT_SPACE, 1'b0);
      add_byte(pnd_pkg::BYTE_NUL, 1'b0);
      add_byte(8'h42, 1'b1);
      add_byte(8'h41, 1'b0);
      add_byte(pnd_pkg::BYTE_SPACE, 1'b0);
      add_byte(pnd_pkg::BYTE_SPACE, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hC0, 1'b0);
      add_byte(8'hE0, 1'b0);
      add_byte(8'h5C, 1'b1);
      // The pads of this open name are emitted after the switch to raw mode.
      add_byte(8'h7F, 1'b0);
      add_byte(pnd_pkg::BYTE_SPACE, 1'b0);
      add_byte(pnd_pkg::BYTE_NUL, 1'b0);
      wait_drained();

      write_mode(1'b1);
      @(negedge clock);
      add_byte(8'h42, 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(8'hA0, 1'b1);
      add_byte(8'h01, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_mode(1'b0);
            1: write_mode(1'b1);
            default: write_mode(1'($urandom_range(0, 1)));
         endcase
         quiet = (phase == 2);
         @(negedge clock);
         add_random_phase(40);
         wait_drained();
      end

      $display("Covered %0d name bytes and %0d checked words over %0d names,",
               items_taken, chars_checked, names_done);
      $display("with %0d mode writes and %0d names past the length limit.",
               mode_writes, overlong_names);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/pnd_pkg.sv
hdl/pnd_ctrl.sv
hdl/pnd_datapath.sv
hdl/petscii_name_display_converter_core.sv
verif/petscii_name_display_converter_core_tb.sv
